@@ rtl/jjy_enc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jjy_enc_pkg;

  // Frame geometry: frame bit (FRAME_BITS - 1 - s) is sent in second s
  localparam int FRAME_BITS = 60;
  localparam int MIN_LSB    = FRAME_BITS - 1 - 8;
  localparam int HOUR_LSB   = FRAME_BITS - 1 - 18;
  localparam int DAY_LSB    = FRAME_BITS - 1 - 33;
  localparam int YEAR_LSB   = FRAME_BITS - 1 - 48;
  localparam int WDAY_LSB   = FRAME_BITS - 1 - 52;
  localparam int HPAR_BIT   = FRAME_BITS - 1 - 36;
  localparam int MPAR_BIT   = FRAME_BITS - 1 - 37;

  // Item kinds
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SYMBOL = 1'b1;

  // Symbol codes
  localparam logic [1:0] SYM_MARKER = 2'd0;
  localparam logic [1:0] SYM_ONE    = 2'd1;
  localparam logic [1:0] SYM_ZERO   = 2'd2;

  // High-carrier durations in ms
  localparam logic [9:0] MS_MARKER = 10'd200;
  localparam logic [9:0] MS_ONE    = 10'd500;
  localparam logic [9:0] MS_ZERO   = 10'd800;

  typedef struct packed {
    logic       action;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [8:0] day_of_year;
    logic [6:0] year_two_digits;
    logic [2:0] weekday;
    logic [5:0] second;
  } in_item_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic [9:0] high_ms;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic                  kind;
    logic                  marker;
    logic [5:0]            bit_idx;
    logic [FRAME_BITS-1:0] frame;
  } cmd_t;

  // Divide by ten through reciprocal multiply, exact for n below 1029
  function automatic logic [6:0] div10(input logic [9:0] n);
    logic [20:0] p;
    p = 21'(n) * 21'd205;
    return p[17:11];
  endfunction

  // Remainder after div10
  function automatic logic [3:0] mod10(input logic [9:0] n, input logic [6:0] q);
    logic [9:0] r;
    r = n - 10'(q) * 10'd10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/jjy_enc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jjy_enc_front (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire jjy_enc_pkg::in_item_t in_data,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output jjy_enc_pkg::cmd_t         push_data
);
  import jjy_enc_pkg::*;

  logic [6:0] m_q, h_q, d_q1, d_q2, y_q, y_q2, s_q;
  logic [3:0] m_u, h_u, d_u, d_t, y_u, y_t, s_r;
  logic [FRAME_BITS-1:0] f;

  // Split the time fields into decimal digits
  always_comb begin
    m_q  = div10(10'(in_data.minute));
    m_u  = mod10(10'(in_data.minute), m_q);
    h_q  = div10(10'(in_data.hour));
    h_u  = mod10(10'(in_data.hour), h_q);
    d_q1 = div10(10'(in_data.day_of_year));
    d_u  = mod10(10'(in_data.day_of_year), d_q1);
    d_q2 = div10(10'(d_q1));
    d_t  = mod10(10'(d_q1), d_q2);
    y_q  = div10(10'(in_data.year_two_digits));
    y_u  = mod10(10'(in_data.year_two_digits), y_q);
    y_q2 = div10(10'(y_q));
    y_t  = mod10(10'(y_q), y_q2);
    s_q  = div10(10'(in_data.second));
    s_r  = mod10(10'(in_data.second), s_q);
  end

  // Assemble the minute frame, parity last
  always_comb begin
    f = '0;
    f[MIN_LSB +: 4]       = m_u;
    f[MIN_LSB + 5 +: 4]   = m_q[3:0];
    f[HOUR_LSB +: 4]      = h_u;
    f[HOUR_LSB + 5 +: 4]  = h_q[3:0];
    f[DAY_LSB +: 4]       = d_u;
    f[DAY_LSB + 5 +: 4]   = d_t;
    f[DAY_LSB + 10 +: 2]  = d_q2[1:0];
    f[YEAR_LSB +: 4]      = y_u;
    f[YEAR_LSB + 4 +: 4]  = y_t;
    f[WDAY_LSB +: 3]      = in_data.weekday;
    f[HPAR_BIT]           = ^f[HOUR_LSB +: 7];
    f[MPAR_BIT]           = ^f[MIN_LSB +: 8];
  end

  // Classify the item and hand it to the queue
  always_comb begin
    push_data.kind    = in_data.action;
    push_data.marker  = (in_data.second == 6'd0) || (s_r == 4'd9) ||
                        (in_data.second > 6'(FRAME_BITS - 1));
    push_data.bit_idx = 6'(FRAME_BITS - 1) - in_data.second;
    push_data.frame   = f;
    push_valid        = in_valid;
    in_ready          = push_ready;
  end

endmodule

`default_nettype wire

@@ rtl/jjy_enc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jjy_enc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire jjy_enc_pkg::cmd_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output jjy_enc_pkg::cmd_t      pop_data
);
  import jjy_enc_pkg::*;

  // Keep at least one pointer bit so a single-entry queue still builds
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/jjy_enc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jjy_enc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire jjy_enc_pkg::cmd_t cmd_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jjy_enc_pkg::out_item_t out_data
);
  import jjy_enc_pkg::*;

  logic [FRAME_BITS-1:0] frame;
  logic                  take;
  logic                  is_load;
  out_item_t             res;

  // Loads never wait; symbols wait for room in the output register
  assign is_load   = (cmd_data.kind == ACT_LOAD);
  assign cmd_ready = is_load || !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;

  // Look up the symbol for this second
  always_comb begin
    if (cmd_data.marker) begin
      res.symbol  = SYM_MARKER;
      res.high_ms = MS_MARKER;
    end else if (frame[cmd_data.bit_idx]) begin
      res.symbol  = SYM_ONE;
      res.high_ms = MS_ONE;
    end else begin
      res.symbol  = SYM_ZERO;
      res.high_ms = MS_ZERO;
    end
  end

  // Hold the current frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (take && is_load) begin
      frame <= cmd_data.frame;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && !is_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jjy_time_code_encoder_core.sv @@
// JJY time-code encoder. A load item (action 0) converts minute, hour, day of
// year, year and weekday into a 60-bit minute frame with hour and minute
// parity and gives no result; a symbol item (action 1) returns the marker,
// one or zero symbol and its high-carrier length for the given second, using
// the frame of the latest load ahead of it. With a queue of two or more
// entries one item is accepted per cycle sustained while the output is not
// stalled; a symbol result passes through the command queue (QUEUE_DEPTH
// entries) and is then captured by the output register.
`timescale 1ns / 1ps
`default_nettype none

module jjy_time_code_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire jjy_enc_pkg::in_item_t in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output jjy_enc_pkg::out_item_t     out_data
);
  import jjy_enc_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd_data;

  // Accept and classify
  jjy_enc_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple front and back
  jjy_enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_data   (cmd_data)
  );

  // Apply loads and emit symbols
  jjy_enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/jjy_enc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jjy_enc_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire jjy_enc_pkg::in_item_t  in_data,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire jjy_enc_pkg::out_item_t out_data
);
  import jjy_enc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // Symbol code and duration agree
  a_sym_ms: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.symbol == SYM_MARKER && out_data.high_ms == MS_MARKER) ||
      (out_data.symbol == SYM_ONE && out_data.high_ms == MS_ONE) ||
      (out_data.symbol == SYM_ZERO && out_data.high_ms == MS_ZERO))
    else $error("symbol and high_ms disagree");

  // Reset leaves no result and an open input
  a_rst_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_rst_in: assert property (@(posedge clk) $past(rst) && !rst |-> in_ready)
    else $error("input not ready right after reset");

  // A load alone into an empty block never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && in_valid && in_ready && in_data.action == ACT_LOAD
      |=> ##1 !out_valid)
    else $error("load item produced a result");

endmodule

bind jjy_time_code_encoder_core jjy_enc_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ dv/tb_jjy_time_code_encoder_core.sv @@
`timescale 1ns / 1ps

module tb_jjy_time_code_encoder_core;
  import jjy_enc_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 288;
  localparam int N_DIRECTED   = 25;
  localparam int PRINT_CAP    = 200;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t result;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Minute frame as the block should hold it, plus the symbols still owed
  logic [FRAME_BITS-1:0] frame_now;
  out_item_t             symbols_due[$];

  int       mismatches     = 0;
  int       quiet_cycles   = 0;
  int       items_sent     = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  dir_row_t dir_table [N_DIRECTED];

  jjy_time_code_encoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Padded BCD: hundreds at bit 10, tens at bit 5, units at bit 0
  function automatic logic [63:0] bcd_padded(input int unsigned n, input int unsigned hmask);
    logic [63:0] h;
    logic [63:0] t;
    logic [63:0] u;
    h = 64'(((n / 100) % 10) & hmask);
    t = 64'((n / 10) % 10);
    u = 64'(n % 10);
    return (h << 10) | (t << 5) | u;
  endfunction

  function automatic logic [63:0] bcd_plain(input int unsigned n);
    return (64'((n / 10) % 10) << 4) | 64'(n % 10);
  endfunction

  function automatic logic [FRAME_BITS-1:0] build_minute_frame(input in_item_t it);
    logic [63:0] f;
    f = bcd_padded(it.minute, 0) << MIN_LSB;
    f |= bcd_padded(it.hour, 0) << HOUR_LSB;
    f |= bcd_padded(it.day_of_year, 3) << DAY_LSB;
    f |= bcd_plain(it.year_two_digits) << YEAR_LSB;
    f |= 64'(it.weekday) << WDAY_LSB;
    // Even parity over the hour bits (seconds 12..18), then the minute bits (1..8)
    f[HPAR_BIT] = ^f[HOUR_LSB +: 7];
    f[MPAR_BIT] = ^f[MIN_LSB +: 8];
    return f[FRAME_BITS-1:0];
  endfunction

  function automatic out_item_t predict_symbol(input logic [FRAME_BITS-1:0] fr,
                                               input logic [5:0] sec);
    out_item_t r;
    if (sec == 0 || sec % 10 == 9 || sec > 59) begin
      r.symbol  = SYM_MARKER;
      r.high_ms = MS_MARKER;
    end else if (fr[FRAME_BITS - 1 - int'(sec)]) begin
      r.symbol  = SYM_ONE;
      r.high_ms = MS_ONE;
    end else begin
      r.symbol  = SYM_ZERO;
      r.high_ms = MS_ZERO;
    end
    return r;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic dir_row_t load_row(input int m, input int h, input int d,
                                        input int y, input int w);
    dir_row_t r;
    r.item                 = random_item();
    r.item.action          = ACT_LOAD;
    r.item.minute          = 6'(m);
    r.item.hour            = 5'(h);
    r.item.day_of_year     = 9'(d);
    r.item.year_two_digits = 7'(y);
    r.item.weekday         = 3'(w);
    r.pinned               = 1'b0;
    r.result               = '0;
    return r;
  endfunction

  function automatic dir_row_t sym_row(input int s);
    dir_row_t r;
    r.item        = random_item();
    r.item.action = ACT_SYMBOL;
    r.item.second = 6'(s);
    r.pinned      = 1'b0;
    r.result      = '0;
    return r;
  endfunction

  function automatic dir_row_t pinned_row(input int s, input logic [1:0] sym,
                                          input logic [9:0] ms);
    dir_row_t r;
    r                = sym_row(s);
    r.pinned         = 1'b1;
    r.result.symbol  = sym;
    r.result.high_ms = ms;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one item, hold it until taken, then advance the prediction
  task automatic send_item(input in_item_t it, input bit pinned, input out_item_t pinned_result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (it.action == ACT_LOAD)
      frame_now = build_minute_frame(it);
    else if (pinned)
      symbols_due.push_back(pinned_result);
    else
      symbols_due.push_back(predict_symbol(frame_now, it.second));
  endtask

  // One minute: load a frame, then ask for a run of consecutive seconds
  task automatic send_minute();
    in_item_t    it;
    int unsigned start;
    int unsigned len;
    it        = random_item();
    it.action = ACT_LOAD;
    if ($urandom_range(9) != 0) begin
      it.minute          = 6'($urandom_range(59));
      it.hour            = 5'($urandom_range(23));
      it.day_of_year     = 9'($urandom_range(366, 1));
      it.year_two_digits = 7'($urandom_range(99));
      it.weekday         = 3'($urandom_range(6));
    end
    send_item(it, 1'b0, '0);
    start = $urandom_range(60);
    len   = $urandom_range(61, 1);
    for (int i = 0; i < int'(len); i++) begin
      it        = random_item();
      it.action = ACT_SYMBOL;
      it.second = 6'((start + i) % 61);
      send_item(it, 1'b0, '0);
    end
    items_sent += 1 + len;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target         = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) begin
        send_minute();
      end else begin
        // Drop in a stray item with every field random
        send_item(random_item(), 1'b0, '0);
        items_sent++;
      end
    end
  endtask

  // Take results and compare each with the oldest symbol owed
  always @(posedge clk) begin : check_results
    out_item_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (symbols_due.size() == 0) begin
          log_mismatch("result with nothing due, symbol", out_data.symbol, 0);
        end else begin
          due = symbols_due.pop_front();
          if (out_data.symbol !== due.symbol)
            log_mismatch("symbol", out_data.symbol, due.symbol);
          if (out_data.high_ms !== due.high_ms)
            log_mismatch("high_ms", out_data.high_ms, due.high_ms);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_jjy_time_code_encoder_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    frame_now      = '0;

    dir_table = '{
      // Empty frame after reset: markers and zeros only
      pinned_row(0, SYM_MARKER, MS_MARKER),
      pinned_row(1, SYM_ZERO, MS_ZERO),
      pinned_row(60, SYM_MARKER, MS_MARKER),
      pinned_row(63, SYM_MARKER, MS_MARKER),
      pinned_row(36, SYM_ZERO, MS_ZERO),
      // Top of the legal ranges
      load_row(59, 23, 366, 99, 6),
      sym_row(1),
      sym_row(8),
      sym_row(36),
      sym_row(37),
      pinned_row(29, SYM_MARKER, MS_MARKER),
      pinned_row(59, SYM_MARKER, MS_MARKER),
      // All field bits set: tens and hundreds digits past the legal range
      load_row(63, 31, 511, 127, 7),
      sym_row(2),
      sym_row(12),
      sym_row(22),
      sym_row(44),
      sym_row(52),
      // All zeros
      load_row(0, 0, 0, 0, 0),
      pinned_row(5, SYM_ZERO, MS_ZERO),
      pinned_row(9, SYM_MARKER, MS_MARKER),
      // Odd bit counts to flip both parity bits
      load_row(1, 1, 1, 1, 1),
      sym_row(8),
      sym_row(36),
      sym_row(37)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i])
      send_item(dir_table[i].item, dir_table[i].pinned, dir_table[i].result);

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(61, 0, PHASE_ITEMS);
    run_phase(0, 61, PHASE_ITEMS);
    run_phase(26, 26, PHASE_ITEMS);
    in_valid <= 1'b0;

    // Drain what is still owed, then give the pipeline time to misbehave
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb_jjy_time_code_encoder_core: done, clean");
    else
      $display("tb_jjy_time_code_encoder_core: done, errors");
    $finish;
  end

endmodule
